### sv/kds_pkg.sv
// Shared constants, types and table builders for the keypad note synthesizer.
`timescale 1ns / 1ps

package kds_pkg;

  // Default build configuration
  localparam int TABLE_DEPTH_DEF  = 1024;
  localparam int TOP_OCTAVE_DEF   = 4;
  localparam int NOTE_ENTRIES_DEF = 61;

  // Field widths
  localparam int KEY_W    = 5;
  localparam int VOL_W    = 7;
  localparam int DAC_W    = 12;
  localparam int OCT_W    = 3;
  localparam int SHAPE_W  = 2;
  localparam int STEP_W   = 10;
  localparam int NOTE_IDX_W = 6;
  localparam int ROM_ENTRIES = 61;

  // Wave sample scaled down by the amplitude percent divisor: -20..20
  localparam int QUOT_W     = 6;
  localparam int SampleDiv  = 100;
  localparam int PEAK       = 2047;
  localparam int MIDSCALE   = 2048;
  localparam int DAC_MAX    = 4095;

  // 2*pi in unsigned Q4.60
  localparam logic [63:0] TWO_PI_Q60 = 64'h6487_ED51_10B4_611A;

  // Key codes
  localparam logic [KEY_W-1:0] KEY_NONE      = 5'd0;
  localparam logic [KEY_W-1:0] KEY_NOTE_LAST = 5'd13;
  localparam logic [KEY_W-1:0] KEY_OCT_UP    = 5'd14;
  localparam logic [KEY_W-1:0] KEY_OCT_DOWN  = 5'd15;
  localparam logic [KEY_W-1:0] KEY_WAVE      = 5'd16;

  // Wave shape codes
  localparam logic [SHAPE_W-1:0] SHAPE_SINE = 2'd0;
  localparam logic [SHAPE_W-1:0] SHAPE_TRI  = 2'd1;
  localparam logic [SHAPE_W-1:0] SHAPE_SAW  = 2'd2;

  // Phase step per note, floor(440*2^((n-33)/12) * 1023/8192)
  localparam logic [STEP_W-1:0] NOTE_STEP_ROM [ROM_ENTRIES] = '{
    10'd8,   10'd8,   10'd9,   10'd9,   10'd10,  10'd10,  10'd11,  10'd12,  10'd12,
    10'd13,  10'd14,  10'd15,  10'd16,  10'd17,  10'd18,  10'd19,  10'd20,  10'd21,
    10'd23,  10'd24,  10'd25,  10'd27,  10'd29,  10'd30,  10'd32,  10'd34,  10'd36,
    10'd38,  10'd41,  10'd43,  10'd46,  10'd48,  10'd51,  10'd54,  10'd58,  10'd61,
    10'd65,  10'd69,  10'd73,  10'd77,  10'd82,  10'd87,  10'd92,  10'd97,  10'd103,
    10'd109, 10'd116, 10'd123, 10'd130, 10'd138, 10'd146, 10'd155, 10'd164, 10'd174,
    10'd184, 10'd195, 10'd207, 10'd219, 10'd232, 10'd246, 10'd261
  };

  // One result item
  typedef struct packed {
    logic               sample_valid;
    logic [DAC_W-1:0]   dac_code;
    logic [OCT_W-1:0]   octave;
    logic [SHAPE_W-1:0] wave_shape;
    logic               key_changed;
  } kds_result_t;

  // (a*b) >> 60 over a full 128-bit product, kept to 64 bits
  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[123:60];
  endfunction

  // trunc(2047*sin(x)) by a Taylor series in Q4.60, x given in Q4.60
  function automatic logic [10:0] quarter_sine(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] scaled;
    x2   = qmul(x, x);
    term = x;
    sum  = x;
    for (int k = 1; k <= 12; k++) begin
      term = qmul(term, x2) / 64'((2 * k) * (2 * k + 1));
      if ((k % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    scaled = qmul(sum, 64'(PEAK));
    return scaled[10:0];
  endfunction

endpackage

### sv/kds_if.sv
// Valid/ready channel interfaces for sample ticks and synthesized results.
`timescale 1ns / 1ps

interface kds_in_if;
  logic       valid;
  logic       ready;
  logic [4:0] key_code;
  logic [6:0] volume;

  modport source (output valid, output key_code, output volume, input ready);
  modport sink   (input valid, input key_code, input volume, output ready);
endinterface

interface kds_out_if;
  logic        valid;
  logic        ready;
  logic        sample_valid;
  logic [11:0] dac_code;
  logic [2:0]  octave;
  logic [1:0]  wave_shape;
  logic        key_changed;

  modport source (output valid, output sample_valid, output dac_code, output octave,
                  output wave_shape, output key_changed, input ready);
  modport sink   (input valid, input sample_valid, input dac_code, input octave,
                  input wave_shape, input key_changed, output ready);
endinterface

### sv/kds_wave.sv
// Wave generator: registered sample of the selected shape, already divided by 100.
`timescale 1ns / 1ps

module kds_wave #(
  parameter int TABLE_DEPTH = kds_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [$clog2(TABLE_DEPTH)-1:0]      phase_i,
  input  logic [kds_pkg::SHAPE_W-1:0]         shape_i,
  output logic signed [kds_pkg::QUOT_W-1:0]   quot_o
);
  import kds_pkg::*;

  localparam int PW      = $clog2(TABLE_DEPTH);
  localparam int QW      = PW - 2;
  localparam int QUARTER = TABLE_DEPTH / 4;
  localparam int HALF    = TABLE_DEPTH / 2;
  localparam int MAG_W   = QUOT_W - 1;
  localparam int TRI_W   = PW + 13;
  localparam int SAW_W   = PW + 12;
  localparam logic [63:0] X_STEP = TWO_PI_Q60 / TABLE_DEPTH;

  typedef logic [MAG_W-1:0] sine_rom_t [QUARTER];

  // Quarter sine table, one entry per phase, already divided by 100
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    logic [10:0] s;
    for (int m = 0; m < QUARTER; m++) begin
      s = quarter_sine(X_STEP * 64'(m));
      rom[m] = MAG_W'(int'(s) / SampleDiv);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  logic [PW-1:0]             tri_p;
  logic [TRI_W-1:0]          tri_a;
  logic [SAW_W-1:0]          saw_a;
  logic signed [13:0]        tri_t;
  logic signed [13:0]        saw_t;
  logic signed [13:0]        lin_s;
  logic [10:0]               lin_mag;
  logic [23:0]               lin_prod;
  logic [MAG_W-1:0]          lin_qmag;
  logic signed [QUOT_W-1:0]  lin_quot;
  logic [PW-1:0]             sine_m;
  logic                      sine_neg;
  logic                      sine_top;
  logic signed [QUOT_W-1:0]  quot_r;

  // Triangle: rising half, then falling half on the lower phase bits
  always_comb begin
    tri_p = phase_i[PW-1] ? {1'b0, phase_i[PW-2:0]} : phase_i;
    tri_a = (TRI_W'(tri_p) << 13) - (TRI_W'(tri_p) << 2);
    if (!phase_i[PW-1]) begin
      tri_t = $signed({1'b0, tri_a[TRI_W-1:PW]}) - 14'sd2047;
      if (tri_t < 0 && tri_a[PW-1:0] != '0) begin
        tri_t = tri_t + 14'sd1;
      end
    end else begin
      tri_t = 14'sd2047 - $signed({1'b0, tri_a[TRI_W-1:PW]});
      if (tri_t > 0 && tri_a[PW-1:0] != '0) begin
        tri_t = tri_t - 14'sd1;
      end
    end
  end

  // Sawtooth: one ramp over the full table
  always_comb begin
    saw_a = (SAW_W'(phase_i) << 12) - (SAW_W'(phase_i) << 1);
    saw_t = $signed({1'b0, saw_a[SAW_W-1:PW]}) - 14'sd2047;
    if (saw_t < 0 && saw_a[PW-1:0] != '0) begin
      saw_t = saw_t + 14'sd1;
    end
  end

  // Divide the linear shapes by 100 toward zero via reciprocal multiply
  always_comb begin
    lin_s    = (shape_i == SHAPE_TRI) ? tri_t : saw_t;
    lin_mag  = (lin_s < 0) ? 11'(-lin_s) : 11'(lin_s);
    lin_prod = 24'(lin_mag) * 24'd5243;
    lin_qmag = lin_prod[23:19];
    lin_quot = (lin_s < 0) ? -$signed({1'b0, lin_qmag}) : $signed({1'b0, lin_qmag});
  end

  // Fold the phase into the first quadrant
  always_comb begin
    sine_neg = 1'b0;
    if (phase_i <= PW'(QUARTER)) begin
      sine_m = phase_i;
    end else if (phase_i <= PW'(HALF)) begin
      sine_m = PW'(HALF) - phase_i;
    end else if (phase_i <= PW'(HALF + QUARTER)) begin
      sine_m   = phase_i - PW'(HALF);
      sine_neg = 1'b1;
    end else begin
      sine_m   = PW'(TABLE_DEPTH) - phase_i;
      sine_neg = 1'b1;
    end
    sine_top = (sine_m == PW'(QUARTER));
  end

  // Register the sample; sine comes from the quarter table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quot_r <= '0;
    end else begin
      case (shape_i) inside
        SHAPE_TRI, SHAPE_SAW: begin
          quot_r <= lin_quot;
        end
        default: begin
          if (sine_top) begin
            quot_r <= sine_neg ? -QUOT_W'(PEAK / SampleDiv) : QUOT_W'(PEAK / SampleDiv);
          end else if (sine_neg) begin
            quot_r <= -$signed({1'b0, SINE_ROM[sine_m[QW-1:0]]});
          end else begin
            quot_r <= $signed({1'b0, SINE_ROM[sine_m[QW-1:0]]});
          end
        end
      endcase
    end
  end

  assign quot_o = quot_r;

endmodule

### sv/keypad_dds_note_synth_top.sv
// Top level of the keypad note synthesizer: key decode, phase state, mixing, output skid.
`timescale 1ns / 1ps

// Keypad DDS note synthesizer.
// in_ch carries one sample tick per transfer: the keypad code and the slider
// volume. out_ch returns exactly one result per tick: sample_valid, the 12-bit
// DAC code (0 when no sample), the octave and wave shape after the tick, and
// whether the key changed. cfg_we/cfg_wdata write sound_enable at any edge.
// A tick's result is registered in the result register, or in the skid when
// out_ch stalls. Throughput: one tick per cycle while out_ch takes results.
// The wave sample for the next tick is looked up in the cycle of the current
// tick from the next phase and shape, so the tick path holds only one multiply
// by the amplitude, an add and a clamp. A two-entry output buffer (result
// register plus skid) lets in_ch take one more tick after out_ch stalls;
// in_ch.ready then drops until the receiver takes a result; it is registered state only.
// Reset (rst_n low, synchronous): phase and step 0, octave 2, sine shape,
// no note held, previous key none, amplitude 100, sound enabled, buffer empty.
module keypad_dds_note_synth_top #(
  parameter int TABLE_DEPTH  = kds_pkg::TABLE_DEPTH_DEF,
  parameter int TOP_OCTAVE   = kds_pkg::TOP_OCTAVE_DEF,
  parameter int NOTE_ENTRIES = kds_pkg::NOTE_ENTRIES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  kds_in_if.sink   in_ch,
  kds_out_if.source out_ch,
  input  logic     cfg_we,
  input  logic     cfg_wdata
);
  import kds_pkg::*;

  localparam int PW = $clog2(TABLE_DEPTH);

  // State
  logic                      sound_en_r;
  logic [PW-1:0]             phase_r,  phase_nxt;
  logic [STEP_W-1:0]         step_r,   step_nxt;
  logic [OCT_W-1:0]          octave_r, octave_nxt;
  logic [SHAPE_W-1:0]        shape_r,  shape_nxt;
  logic                      held_r,   held_nxt;
  logic [KEY_W-1:0]          prev_key_r, prev_key_nxt;
  logic [VOL_W-1:0]          amp_r,    amp_nxt;

  // Output buffer
  logic                      out_valid_r, out_valid_nxt;
  logic                      skid_valid_r, skid_valid_nxt;
  kds_result_t               out_data_r, out_data_nxt;
  kds_result_t               skid_data_r, skid_data_nxt;

  logic                      in_fire;
  logic                      out_fire;
  logic                      play;
  logic                      key_changed;
  logic [NOTE_IDX_W-1:0]     note_idx;
  logic signed [QUOT_W-1:0]  quot;
  logic signed [13:0]        mix;
  logic [DAC_W-1:0]          dac_sat;
  kds_result_t               result;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_valid_r && out_ch.ready;
  assign play     = sound_en_r && held_r;
  assign key_changed = (in_ch.key_code != prev_key_r);
  assign note_idx = NOTE_IDX_W'(in_ch.key_code - 5'd1) + (NOTE_IDX_W'(octave_r) << 3)
                  + (NOTE_IDX_W'(octave_r) << 2);

  // Wave sample for the phase and shape the next tick will see
  kds_wave #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_wave (
    .clk    (clk),
    .rst_n  (rst_n),
    .phase_i(phase_nxt),
    .shape_i(shape_nxt),
    .quot_o (quot)
  );

  // Latch a nonzero volume, advance phase, decode a changed key
  always_comb begin
    phase_nxt    = phase_r;
    step_nxt     = step_r;
    octave_nxt   = octave_r;
    shape_nxt    = shape_r;
    held_nxt     = held_r;
    prev_key_nxt = prev_key_r;
    amp_nxt      = amp_r;
    if (in_fire) begin
      if (in_ch.volume != '0) begin
        amp_nxt = in_ch.volume;
      end
      if (play) begin
        phase_nxt = phase_r + PW'(step_r);
      end
      if (key_changed) begin
        prev_key_nxt = in_ch.key_code;
        unique case (in_ch.key_code)
          KEY_NONE: begin
            held_nxt = 1'b0;
          end
          KEY_OCT_UP: begin
            if (octave_r < OCT_W'(TOP_OCTAVE)) begin
              octave_nxt = octave_r + 3'd1;
            end
          end
          KEY_OCT_DOWN: begin
            if (octave_r != '0) begin
              octave_nxt = octave_r - 3'd1;
            end
          end
          KEY_WAVE: begin
            shape_nxt = (shape_r >= SHAPE_SAW) ? SHAPE_SINE : shape_r + 2'd1;
          end
          default: begin
            if (in_ch.key_code <= KEY_NOTE_LAST) begin
              step_nxt = (note_idx < NOTE_IDX_W'(NOTE_ENTRIES)) ?
                         NOTE_STEP_ROM[note_idx] : '0;
              held_nxt = 1'b1;
            end else begin
              step_nxt = '0;
            end
          end
        endcase
      end
    end
  end

  // Scale the sample by the amplitude, center and clamp
  always_comb begin
    mix = 14'(quot) * $signed({7'd0, (in_ch.volume != '0) ? in_ch.volume : amp_r})
        + 14'sd2048;
    if (mix < 0) begin
      dac_sat = '0;
    end else if (mix > 14'sd4095) begin
      dac_sat = DAC_W'(DAC_MAX);
    end else begin
      dac_sat = mix[DAC_W-1:0];
    end
    result.sample_valid = play;
    result.dac_code     = play ? dac_sat : '0;
    result.octave       = octave_nxt;
    result.wave_shape   = shape_nxt;
    result.key_changed  = key_changed;
  end

  // Load the result register, spill into the skid when the receiver stalls
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (out_fire) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_r || out_ch.ready) begin
        out_data_nxt  = result;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = result;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sound_en_r   <= 1'b1;
      phase_r      <= '0;
      step_r       <= '0;
      octave_r     <= 3'd2;
      shape_r      <= SHAPE_SINE;
      held_r       <= 1'b0;
      prev_key_r   <= KEY_NONE;
      amp_r        <= 7'd100;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        sound_en_r <= cfg_wdata;
      end
      phase_r      <= phase_nxt;
      step_r       <= step_nxt;
      octave_r     <= octave_nxt;
      shape_r      <= shape_nxt;
      held_r       <= held_nxt;
      prev_key_r   <= prev_key_nxt;
      amp_r        <= amp_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Hold result payloads
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign in_ch.ready         = !skid_valid_r;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.sample_valid = out_data_r.sample_valid;
  assign out_ch.dac_code     = out_data_r.dac_code;
  assign out_ch.octave       = out_data_r.octave;
  assign out_ch.wave_shape   = out_data_r.wave_shape;
  assign out_ch.key_changed  = out_data_r.key_changed;

  // The skid entry only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without a waiting result");

  // A silent tick leaves the phase where it was
  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !play) |=> $stable(phase_r))
    else $error("phase moved on a silent tick");

  // Octave stays within its range
  a_octave_range: assert property (@(posedge clk) disable iff (!rst_n)
    octave_r <= OCT_W'(TOP_OCTAVE))
    else $error("octave beyond top octave");

  // A result without a sample carries a zero code
  a_silent_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.sample_valid) |-> (out_data_r.dac_code == '0))
    else $error("silent result with nonzero code");

endmodule

### dv/tb_keypad_dds_note_synth_top.sv
// Self-checking testbench for the keypad DDS note synthesizer top level.
`timescale 1ns / 1ps

module tb_keypad_dds_note_synth_top;
  import kds_pkg::*;

  localparam int WAVE_LEN       = TABLE_DEPTH_DEF;
  localparam int OCT_TOP        = TOP_OCTAVE_DEF;
  localparam int PITCH_ENTRIES  = NOTE_ENTRIES_DEF;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SEGMENTS       = 7;
  localparam int SEG_TICKS      = 247;
  localparam int DIRECTED_TICKS = 25;
  localparam int MAX_REPORTS    = 10;

  localparam logic [63:0] RAD_FULL_Q60 = 64'h6487_ED51_10B4_611A;

  // Keys that the package leaves unnamed
  localparam logic [KEY_W-1:0] KEY_NOTE_C     = 5'd1;
  localparam logic [KEY_W-1:0] KEY_NOTE_E     = 5'd5;
  localparam logic [KEY_W-1:0] KEY_NOTE_B     = 5'd12;
  localparam logic [KEY_W-1:0] KEY_OTHER      = 5'd17;
  localparam logic [KEY_W-1:0] KEY_UNUSED_LO  = 5'd18;
  localparam logic [KEY_W-1:0] KEY_UNUSED_TOP = 5'd31;

  // Phase increment per note index, octave 0 first
  localparam logic [STEP_W-1:0] PITCH_STEP [61] = '{
    10'd8,   10'd8,   10'd9,   10'd9,   10'd10,  10'd10,  10'd11,  10'd12,  10'd12,
    10'd13,  10'd14,  10'd15,  10'd16,  10'd17,  10'd18,  10'd19,  10'd20,  10'd21,
    10'd23,  10'd24,  10'd25,  10'd27,  10'd29,  10'd30,  10'd32,  10'd34,  10'd36,
    10'd38,  10'd41,  10'd43,  10'd46,  10'd48,  10'd51,  10'd54,  10'd58,  10'd61,
    10'd65,  10'd69,  10'd73,  10'd77,  10'd82,  10'd87,  10'd92,  10'd97,  10'd103,
    10'd109, 10'd116, 10'd123, 10'd130, 10'd138, 10'd146, 10'd155, 10'd164, 10'd174,
    10'd184, 10'd195, 10'd207, 10'd219, 10'd232, 10'd246, 10'd261
  };

  // Opening sequence: notes, the top octave limit, every shape, odd keys, volume extremes
  localparam logic [KEY_W-1:0] OPENING_KEY [DIRECTED_TICKS] = '{
    KEY_NOTE_C, KEY_NOTE_C, KEY_NOTE_LAST, KEY_NOTE_LAST, KEY_OCT_UP,
    KEY_NONE, KEY_OCT_UP, KEY_NONE, KEY_OCT_UP, KEY_NOTE_LAST,
    KEY_NOTE_LAST, KEY_WAVE, KEY_NOTE_E, KEY_NOTE_E, KEY_WAVE,
    KEY_NOTE_B, KEY_NOTE_B, KEY_NOTE_B, KEY_WAVE, KEY_OCT_DOWN,
    KEY_OTHER, KEY_OTHER, KEY_OCT_DOWN, KEY_UNUSED_TOP, KEY_NONE
  };
  localparam logic [VOL_W-1:0] OPENING_VOL [DIRECTED_TICKS] = '{
    7'd100, 7'd0, 7'd127, 7'd0, 7'd50,
    7'd0, 7'd0, 7'd0, 7'd0, 7'd100,
    7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
    7'd127, 7'd0, 7'd0, 7'd0, 7'd1,
    7'd0, 7'd0, 7'd0, 7'd64, 7'd0
  };

  typedef enum logic {OP_TICK, OP_SET_ENABLE} keypad_op_t;

  typedef struct {
    keypad_op_t      op;
    logic [KEY_W-1:0] key;
    logic [VOL_W-1:0] vol;
    logic            enable;
    int unsigned     gap;
  } keypad_event_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic cfg_we    = 1'b0;
  logic cfg_wdata = 1'b0;

  logic             tick_valid = 1'b0;
  logic [KEY_W-1:0] tick_key   = '0;
  logic [VOL_W-1:0] tick_vol   = '0;
  logic             take_ready = 1'b0;

  keypad_event_t keypad_events [$];
  kds_result_t   owed_results [$];
  int            results_owed = 0;
  int            fail_count   = 0;
  int            results_taken = 0;
  int            idle_cycles  = 0;

  // Driver and receiver pacing
  keypad_event_t head;
  int unsigned   gap_left    = 0;
  int unsigned   settle_left = 0;
  int unsigned   rx_stall_left = 0;
  int unsigned   rx_calm_left  = 0;

  // Synthesizer state as the checker sees it
  logic              synth_enabled;
  logic [STEP_W-1:0] phase_acc;
  logic [STEP_W-1:0] step_now;
  logic [OCT_W-1:0]  octave_now;
  logic [SHAPE_W-1:0] shape_now;
  logic              note_on;
  logic [KEY_W-1:0]  last_key;
  logic [VOL_W-1:0]  amp_pct;

  kds_in_if  keypad_ch ();
  kds_out_if sample_ch ();

  assign keypad_ch.valid    = tick_valid;
  assign keypad_ch.key_code = tick_key;
  assign keypad_ch.volume   = tick_vol;
  assign sample_ch.ready    = take_ready;

  keypad_dds_note_synth_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (keypad_ch),
    .out_ch   (sample_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Q4.60 product, keeping bits 123:60 of the full result
  function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] wide;
    wide = 128'(a) * 128'(b);
    return 64'(wide >> 60);
  endfunction

  // First-quadrant sine scaled to 2047, Taylor series to the 25th power
  function automatic int sine_quarter(input int m);
    logic [63:0] x;
    logic [63:0] x_sq;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] scaled;
    if (m >= WAVE_LEN / 4) begin
      return PEAK;
    end
    x    = (RAD_FULL_Q60 / 64'(WAVE_LEN)) * 64'(m);
    x_sq = q60_mul(x, x);
    term = x;
    acc  = x;
    for (int k = 1; k <= 12; k++) begin
      term = q60_mul(term, x_sq) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    scaled = q60_mul(acc, 64'd2047);
    return int'(scaled[31:0]);
  endfunction

  // Signed wave value at a phase for the given shape
  function automatic int wave_value(input logic [SHAPE_W-1:0] shape, input int p);
    longint d;
    longint pp;
    longint num;
    d  = WAVE_LEN;
    pp = p;
    if (shape == SHAPE_TRI) begin
      if (pp < d / 2) begin
        num = 8188 * pp - 2047 * d;
      end else begin
        num = 2047 * d - 8188 * (pp - d / 2);
      end
      return int'(num / d);
    end
    if (shape == SHAPE_SAW) begin
      return int'((4094 * pp - 2047 * d) / d);
    end
    if (p <= WAVE_LEN / 4) begin
      return sine_quarter(p);
    end
    if (p <= WAVE_LEN / 2) begin
      return sine_quarter(WAVE_LEN / 2 - p);
    end
    if (p <= 3 * WAVE_LEN / 4) begin
      return -sine_quarter(p - WAVE_LEN / 2);
    end
    return -sine_quarter(WAVE_LEN - p);
  endfunction

  // Advance the synthesizer by one sample tick and return its result
  function automatic kds_result_t synth_tick(input logic [KEY_W-1:0] key,
                                             input logic [VOL_W-1:0] vol);
    kds_result_t res;
    int          s;
    int          v;
    int          idx;
    res = '0;
    if (vol != 0) begin
      amp_pct = vol;
    end
    // Emit a sample from the current phase, then step the phase
    if (synth_enabled && note_on) begin
      s = wave_value(shape_now, int'(phase_acc));
      v = (s / SampleDiv) * int'(amp_pct) + MIDSCALE;
      if (v < 0) begin
        v = 0;
      end
      if (v > DAC_MAX) begin
        v = DAC_MAX;
      end
      res.sample_valid = 1'b1;
      res.dac_code     = v[DAC_W-1:0];
      phase_acc        = phase_acc + step_now;
    end
    // Act on a change of key only
    if (key != last_key) begin
      res.key_changed = 1'b1;
      if (key == KEY_NONE) begin
        note_on = 1'b0;
      end else if (key == KEY_OCT_UP) begin
        if (octave_now < OCT_TOP) begin
          octave_now = octave_now + 1'b1;
        end
      end else if (key == KEY_OCT_DOWN) begin
        if (octave_now > 0) begin
          octave_now = octave_now - 1'b1;
        end
      end else if (key == KEY_WAVE) begin
        shape_now = (shape_now >= SHAPE_SAW) ? SHAPE_SINE : shape_now + 1'b1;
      end else if (key <= KEY_NOTE_LAST) begin
        idx = int'(key) - 1 + 12 * int'(octave_now);
        step_now = (idx < PITCH_ENTRIES && idx < ROM_ENTRIES) ? PITCH_STEP[idx] : '0;
        note_on  = 1'b1;
      end else begin
        step_now = '0;
      end
      last_key = key;
    end
    res.octave     = octave_now;
    res.wave_shape = shape_now;
    return res;
  endfunction

  function automatic string show(input kds_result_t r);
    return $sformatf("valid=%0b dac=%0d octave=%0d shape=%0d changed=%0b",
                     r.sample_valid, r.dac_code, r.octave, r.wave_shape, r.key_changed);
  endfunction

  task automatic log_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("ERROR: %s", msg);
    end
  endtask

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 88) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return KEY_W'($urandom_range(int'(KEY_NOTE_C), int'(KEY_NOTE_LAST)));
    end
    if (r < 65) begin
      return KEY_NONE;
    end
    if (r < 73) begin
      return KEY_OCT_UP;
    end
    if (r < 81) begin
      return KEY_OCT_DOWN;
    end
    if (r < 89) begin
      return KEY_WAVE;
    end
    if (r < 93) begin
      return KEY_OTHER;
    end
    return KEY_W'($urandom_range(int'(KEY_UNUSED_LO), int'(KEY_UNUSED_TOP)));
  endfunction

  function automatic logic [VOL_W-1:0] pick_volume();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return '0;
    end
    if (r < 90) begin
      return VOL_W'($urandom_range(1, 100));
    end
    return VOL_W'($urandom_range(101, 127));
  endfunction

  function automatic void add_tick(input logic [KEY_W-1:0] key, input logic [VOL_W-1:0] vol,
                                   input int unsigned gap);
    keypad_event_t ev;
    ev.op     = OP_TICK;
    ev.key    = key;
    ev.vol    = vol;
    ev.enable = 1'b0;
    ev.gap    = gap;
    keypad_events.push_back(ev);
  endfunction

  function automatic void add_enable_write(input logic en);
    keypad_event_t ev;
    ev.op     = OP_SET_ENABLE;
    ev.key    = KEY_NONE;
    ev.vol    = '0;
    ev.enable = en;
    ev.gap    = 0;
    keypad_events.push_back(ev);
  endfunction

  // Feed ticks and drain-then-write config steps to the channel
  always @(posedge clk) begin : keypad_driver
    logic push_tick;
    logic push_cfg;
    logic holding;
    push_tick = 1'b0;
    push_cfg  = 1'b0;
    holding   = tick_valid && !keypad_ch.ready;
    if (!rst_n) begin
      holding     = 1'b0;
      gap_left    = 0;
      settle_left = SETTLE_CYCLES;
    end else if (holding) begin
      // hold the tick until the block takes it
    end else if (gap_left != 0) begin
      gap_left--;
    end else if (keypad_events.size() != 0) begin
      if (keypad_events[0].op == OP_TICK) begin
        head      = keypad_events.pop_front();
        push_tick = 1'b1;
        gap_left  = head.gap;
      end else if (tick_valid || results_owed != 0) begin
        // wait until every result is back before touching the register
        settle_left = SETTLE_CYCLES;
      end else if (settle_left != 0) begin
        settle_left--;
      end else begin
        head        = keypad_events.pop_front();
        push_cfg    = 1'b1;
        settle_left = SETTLE_CYCLES;
      end
    end
    tick_valid <= push_tick || holding;
    if (push_tick) begin
      tick_key <= head.key;
      tick_vol <= head.vol;
    end
    cfg_we <= push_cfg;
    if (push_cfg) begin
      cfg_wdata <= head.enable;
    end
  end

  // Check each result transfer, predict each tick transfer, pace the receiver
  always @(posedge clk) begin : sample_monitor
    kds_result_t got;
    kds_result_t want;
    logic        ready_nxt;
    ready_nxt = 1'b0;
    if (!rst_n) begin
      synth_enabled = 1'b1;
      phase_acc     = '0;
      step_now      = '0;
      octave_now    = 3'd2;
      shape_now     = SHAPE_SINE;
      note_on       = 1'b0;
      last_key      = KEY_NONE;
      amp_pct       = 7'd100;
      owed_results.delete();
      rx_stall_left = 0;
      rx_calm_left  = 0;
    end else begin
      if (cfg_we) begin
        synth_enabled = cfg_wdata;
      end
      if (sample_ch.valid && sample_ch.ready) begin
        got.sample_valid = sample_ch.sample_valid;
        got.dac_code     = sample_ch.dac_code;
        got.octave       = sample_ch.octave;
        got.wave_shape   = sample_ch.wave_shape;
        got.key_changed  = sample_ch.key_changed;
        if (owed_results.size() == 0) begin
          log_failure($sformatf("result %0d with no tick pending: %s",
                                results_taken, show(got)));
        end else begin
          want = owed_results.pop_front();
          if (got !== want) begin
            log_failure($sformatf("result %0d: expected %s, got %s",
                                  results_taken, show(want), show(got)));
          end
        end
        results_taken++;
      end
      if (keypad_ch.valid && keypad_ch.ready) begin
        owed_results.push_back(synth_tick(keypad_ch.key_code, keypad_ch.volume));
      end
      // Stall at random, with quiet stretches of steady acceptance
      if (rx_stall_left != 0) begin
        rx_stall_left--;
      end else begin
        ready_nxt = 1'b1;
        if (rx_calm_left != 0) begin
          rx_calm_left--;
        end else if ($urandom_range(0, 9) == 0) begin
          rx_stall_left = pick_gap();
          if ($urandom_range(0, 19) == 0) begin
            rx_calm_left = $urandom_range(50, 300);
          end
        end
      end
    end
    take_ready   <= ready_nxt;
    results_owed <= owed_results.size();
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if ((keypad_ch.valid && keypad_ch.ready) || (sample_ch.valid && sample_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [KEY_W-1:0] key;
    int               made;
    int               run_len;
    logic             calm;
    // Opening directed sequence after an explicit enable write
    add_enable_write(1'b1);
    for (int i = 0; i < DIRECTED_TICKS; i++) begin
      add_tick(OPENING_KEY[i], OPENING_VOL[i], pick_gap());
    end
    // Random segments, each behind a register write; some run silent
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      add_enable_write((seg % 3 == 0) ? 1'b0 : 1'b1);
      made = 0;
      while (made < SEG_TICKS) begin
        key     = pick_key();
        run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
        calm    = ($urandom_range(0, 4) == 0);
        for (int j = 0; j < run_len; j++) begin
          add_tick(key, pick_volume(), calm ? 0 : pick_gap());
          made++;
        end
      end
    end
    add_enable_write(1'b1);
    add_tick(KEY_NOTE_C, 7'd100, 0);
    add_tick(KEY_NOTE_C, 7'd0, 0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Drain everything, then allow for late or stray results
    wait (keypad_events.size() == 0);
    do begin
      @(posedge clk);
    end while (tick_valid || results_owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (owed_results.size() != 0) begin
      log_failure($sformatf("%0d results never arrived", owed_results.size()));
    end
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
